@@ hdl/peer_poll_scheduler_macros.svh @@
// assertion helpers for the poll scheduler, sampled on clock, off during reset
`ifndef PEER_POLL_SCHEDULER_MACROS_SVH
`define PEER_POLL_SCHEDULER_MACROS_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/pps_pkg.sv @@
`timescale 1ns / 1ps

package pps_pkg;

   localparam int MASK_W = 8;
   localparam int IDX_W = 4;
   localparam int CNT_W = 8;
   localparam int INTERVAL_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int ERR_EVERY = 4;
   localparam int ERR_BITS = $clog2(ERR_EVERY);

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd50;
   localparam logic [CNT_W-1:0] LEVEL_MAX = 8'd255;

   typedef enum logic {
      OP_TICK   = 1'b0,
      OP_ANSWER = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_EXCHANGE_ENABLE = 2'd0,
      CSR_PEER_MASK       = 2'd1,
      CSR_POLL_INTERVAL   = 2'd2
   } csr_index_type;

   // outcome of one poll slot scan
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] next_step;
   } scan_result_type;

endpackage

@@ hdl/pps_if.sv @@
`timescale 1ns / 1ps

interface pps_req_if;
   import pps_pkg::*;
   logic         valid;
   logic         ready;
   op_type       op;
   logic [3:0]   answer_peer;
   modport source (output valid, output op, output answer_peer, input ready);
   modport sink (input valid, input op, input answer_peer, output ready);
endinterface

interface pps_rsp_if;
   import pps_pkg::*;
   logic             valid;
   logic             ready;
   logic             poll_issued;
   logic [3:0]       poll_peer;
   logic [CNT_W-1:0] peer_poll_count;
   logic [CNT_W-1:0] peer_error_level;
   modport source (output valid, output poll_issued, output poll_peer,
                   output peer_poll_count, output peer_error_level, input ready);
   modport sink (input valid, input poll_issued, input poll_peer,
                 input peer_poll_count, input peer_error_level, output ready);
endinterface

interface pps_csr_if;
   import pps_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [1:0]            index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/pps_scan.sv @@
`timescale 1ns / 1ps

module pps_scan #(
   parameter int PEERS = 8
) (
   input  logic [pps_pkg::MASK_W-1:0]   peer_mask,
   input  logic [$clog2(PEERS)-1:0]     step,
   output pps_pkg::scan_result_type     result
);
   import pps_pkg::*;

   logic [2*MASK_W-1:0] mask_wide;
   logic [PEERS-1:0]    peer_on;
   logic                found;
   logic [IDX_W-1:0]    idx;
   logic [IDX_W-1:0]    idx_plus;

   // peers past the mask width never take part
   assign mask_wide = {{MASK_W{1'b0}}, peer_mask};
   assign peer_on = mask_wide[PEERS-1:0];

   // lowest enabled peer at or above the current step
   always_comb begin
      found = 1'b0;
      idx = '0;
      for (int i = 0; i < PEERS; i++) begin
         if (!found && peer_on[i] && (i >= int'(step))) begin
            found = 1'b1;
            idx = IDX_W'(i);
         end
      end
   end

   assign idx_plus = idx + IDX_W'(1);

   always_comb begin
      if (found) begin
         result.hit = 1'b1;
         result.idx = idx;
         result.next_step = (idx_plus == IDX_W'(PEERS)) ? '0 : idx_plus;
      end else begin
         // wrapped once to the first peer
         result.hit = peer_on[0];
         result.idx = '0;
         result.next_step = IDX_W'(1);
      end
   end

endmodule

@@ hdl/peer_poll_scheduler.sv @@
`timescale 1ns / 1ps
// channel   direction  contents
// req_ch    in         op, answer_peer
// rsp_ch    out        poll_issued, poll_peer, peer_poll_count, peer_error_level
// csr_ch    in         index, data (register writes, always ready)
//
// one request per cycle sustained while the response register drains; a request
// passes the input register, then the response register; the single update stage
// reads and writes the per-peer counters.
// reset clears the counters, the tick count, the scan step and the valid flags, and loads the config defaults.
// a stalled response holds its register; the input stage keeps taking
// requests as long as the response register drains.

module peer_poll_scheduler #(
   parameter int PEERS = 8
) (
   input  logic      clock,
   input  logic      reset,
   pps_req_if.sink   req_ch,
   pps_rsp_if.source rsp_ch,
   pps_csr_if.sink   csr_ch
);
   import pps_pkg::*;

   localparam int IW = $clog2(PEERS);

   // configuration
   logic                  exch_en_ff;
   logic [MASK_W-1:0]     peer_mask_ff;
   logic [INTERVAL_W-1:0] interval_ff;

   // state
   logic [INTERVAL_W-1:0] tick_ff, tick_in;
   logic [IW-1:0]         step_ff, step_in;
   logic [CNT_W-1:0]      count_ff [PEERS];
   logic [CNT_W-1:0]      level_ff [PEERS];

   // input stage
   logic       s1_valid_ff;
   op_type     s1_op_ff;
   logic [3:0] s1_peer_ff;

   // response stage
   logic             rsp_valid_ff;
   logic             rsp_issued_ff, rsp_issued_in;
   logic [3:0]       rsp_peer_ff, rsp_peer_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [CNT_W-1:0] rsp_level_ff, rsp_level_in;

   logic             s1_fire;
   logic             slot;
   logic             do_poll;
   logic             answer_ok;
   logic [IW-1:0]    poll_idx;
   logic [IW-1:0]    answer_idx;
   logic [3:0]       answer_minus;
   logic [CNT_W-1:0] count_new;
   logic [CNT_W-1:0] level_new;
   logic [INTERVAL_W-1:0] tick_plus;
   scan_result_type  scan;
   logic             rsp_peer_ok;
   logic             rsp_blank;

   pps_scan #(.PEERS(PEERS)) u_scan (
      .peer_mask (peer_mask_ff),
      .step      (step_ff),
      .result    (scan)
   );

   assign s1_fire = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign csr_ch.ready = 1'b1;

   assign tick_plus = tick_ff + INTERVAL_W'(1);
   assign slot = (s1_op_ff == OP_TICK) && exch_en_ff && (tick_plus >= interval_ff);
   assign do_poll = slot && scan.hit;
   assign poll_idx = scan.idx[IW-1:0];

   assign answer_minus = s1_peer_ff - 4'd1;
   assign answer_idx = answer_minus[IW-1:0];
   assign answer_ok = (s1_op_ff == OP_ANSWER) && (s1_peer_ff != 4'd0)
                      && ({1'b0, s1_peer_ff} <= 5'(PEERS));

   assign count_new = count_ff[poll_idx] + CNT_W'(1);
   assign level_new = ((count_new[ERR_BITS-1:0] == '0) && (level_ff[poll_idx] != LEVEL_MAX))
                      ? level_ff[poll_idx] + CNT_W'(1) : level_ff[poll_idx];

   always_comb begin
      tick_in = tick_ff;
      step_in = step_ff;
      if ((s1_op_ff == OP_TICK) && exch_en_ff) begin
         tick_in = slot ? '0 : tick_plus;
         if (slot) begin
            step_in = scan.next_step[IW-1:0];
         end
      end
   end

   always_comb begin
      rsp_issued_in = do_poll;
      rsp_peer_in = do_poll ? scan.idx + 4'd1 : 4'd0;
      rsp_count_in = do_poll ? count_new : '0;
      rsp_level_in = do_poll ? level_new : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exch_en_ff <= 1'b0;
         peer_mask_ff <= '0;
         interval_ff <= INTERVAL_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_EXCHANGE_ENABLE: exch_en_ff <= csr_ch.data[0];
            CSR_PEER_MASK:       peer_mask_ff <= csr_ch.data[MASK_W-1:0];
            CSR_POLL_INTERVAL:   interval_ff <= csr_ch.data[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         step_ff <= '0;
         for (int i = 0; i < PEERS; i++) begin
            count_ff[i] <= '0;
            level_ff[i] <= '0;
         end
      end else if (s1_fire) begin
         tick_ff <= tick_in;
         step_ff <= step_in;
         if (do_poll) begin
            count_ff[poll_idx] <= count_new;
            level_ff[poll_idx] <= level_new;
         end
         if (answer_ok) begin
            count_ff[answer_idx] <= '0;
            level_ff[answer_idx] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_op_ff <= req_ch.op;
         s1_peer_ff <= req_ch.answer_peer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_issued_ff <= rsp_issued_in;
         rsp_peer_ff <= rsp_peer_in;
         rsp_count_ff <= rsp_count_in;
         rsp_level_ff <= rsp_level_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.poll_issued = rsp_issued_ff;
   assign rsp_ch.poll_peer = rsp_peer_ff;
   assign rsp_ch.peer_poll_count = rsp_count_ff;
   assign rsp_ch.peer_error_level = rsp_level_ff;

   assign rsp_peer_ok = (rsp_peer_ff != 4'd0) && ({1'b0, rsp_peer_ff} <= 5'(PEERS))
                        && (rsp_peer_ff <= 4'(MASK_W));
   assign rsp_blank = (rsp_peer_ff == 4'd0) && (rsp_count_ff == '0)
                      && (rsp_level_ff == '0);

`include "peer_poll_scheduler_macros.svh"

   // a poll always names a peer within the peer count and the mask width
   `PPS_ASSERT_NOW(a_poll_peer, rsp_valid_ff && rsp_issued_ff, rsp_peer_ok, "bad poll peer")

   // a response without a poll carries no counts
   `PPS_ASSERT_NOW(a_idle_blank, rsp_valid_ff && !rsp_issued_ff, rsp_blank, "stray payload")

   // scan state only moves when a request is processed
   `PPS_ASSERT_NEXT(a_step_hold, !s1_fire, $stable(step_ff), "scan step moved while idle")
   `PPS_ASSERT_NEXT(a_tick_hold, !s1_fire, $stable(tick_ff), "tick count moved while idle")

   // a processed request always leaves a response pending
   `PPS_ASSERT_NEXT(a_rsp_after_fire, s1_fire, rsp_valid_ff, "request left no response")

endmodule
